// ===== hdl/lpt_pkg.sv =====
// Shared types and constants of the LPT shard assigner.
// Holds field widths, the controller state type and the command/status structs.
// No dependencies; compile this file first.
package lpt_pkg;

    // Field widths of the channel words, the configuration port and the shard totals.
    localparam int ID_W    = 16;
    localparam int LOAD_W  = 32;
    localparam int TOTAL_W = 40;
    localparam int SHARD_W = 4;
    localparam int CFG_W   = 5;

    // Controller states.
    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_CLEAR,
        ST_FIND_SETUP,
        ST_FIND,
        ST_MIN_SETUP,
        ST_MIN,
        ST_ASSIGN
    } lpt_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_init;
        logic clr_run;
        logic find_init;
        logic find_run;
        logic min_init;
        logic min_run;
        logic assign_item;
    } lpt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic find_done;
        logic min_done;
        logic out_free;
        logic last_item;
    } lpt_status_t;

endpackage

// ===== hdl/lpt_channels.sv =====
// Valid/ready channel interfaces of the LPT shard assigner.
// Depends on lpt_pkg for the field widths.
interface lpt_item_if import lpt_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   item_id;
    logic [LOAD_W-1:0] item_load;
    logic              batch_last;

    modport source (output valid, item_id, item_load, batch_last, input ready);
    modport sink   (input valid, item_id, item_load, batch_last, output ready);
endinterface

interface lpt_result_if import lpt_pkg::*;;
    logic               valid;
    logic               ready;
    logic [ID_W-1:0]    out_id;
    logic [SHARD_W-1:0] shard_index;
    logic               out_last;

    modport source (output valid, out_id, shard_index, out_last, input ready);
    modport sink   (input valid, out_id, shard_index, out_last, output ready);
endinterface

// ===== hdl/lpt_ctrl.sv =====
// Controller state machine of the LPT shard assigner.
// Sequences collection, shard clearing, max and min scans and assignment.
// Depends on lpt_pkg.
module lpt_ctrl import lpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_last,
    input  lpt_status_t status,
    output logic        in_ready,
    output lpt_cmd_t    cmd
);

    lpt_state_t state_reg;
    lpt_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (in_valid && in_last)
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                if (status.clr_done)
                begin
                    state_next = ST_FIND_SETUP;
                end
            end
            ST_FIND_SETUP:
            begin
                state_next = ST_FIND;
            end
            ST_FIND:
            begin
                if (status.find_done)
                begin
                    state_next = ST_MIN_SETUP;
                end
            end
            ST_MIN_SETUP:
            begin
                state_next = ST_MIN;
            end
            ST_MIN:
            begin
                if (status.min_done)
                begin
                    state_next = ST_ASSIGN;
                end
            end
            ST_ASSIGN:
            begin
                if (status.out_free)
                begin
                    state_next = status.last_item ? ST_COLLECT : ST_FIND_SETUP;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // Output logic.
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_COLLECT:
            begin
                in_ready     = 1'b1;
                cmd.clr_init = 1'b1;
            end
            ST_CLEAR:
            begin
                cmd.clr_run = 1'b1;
            end
            ST_FIND_SETUP:
            begin
                cmd.find_init = 1'b1;
            end
            ST_FIND:
            begin
                cmd.find_run = 1'b1;
            end
            ST_MIN_SETUP:
            begin
                cmd.min_init = 1'b1;
            end
            ST_MIN:
            begin
                cmd.min_run = 1'b1;
            end
            ST_ASSIGN:
            begin
                cmd.assign_item = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/lpt_datapath.sv =====
// Datapath of the LPT shard assigner: item store, shard totals, scans, output word.
// Runs on commands from lpt_ctrl and reports status back to it.
// Depends on lpt_pkg.
module lpt_datapath import lpt_pkg::*;
#(
    parameter int MAX_ITEMS  = 64,
    parameter int MAX_SHARDS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                in_accept,
    input  logic [ID_W-1:0]     in_id,
    input  logic [LOAD_W-1:0]   in_load,
    input  lpt_cmd_t            cmd,
    output lpt_status_t         status,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [ID_W-1:0]     out_id,
    output logic [SHARD_W-1:0]  out_shard,
    output logic                out_last
);

    localparam int IT_IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W    = $clog2(MAX_ITEMS + 1);
    localparam int SH_IDX_W = (MAX_SHARDS > 1) ? $clog2(MAX_SHARDS) : 1;
    localparam int SH_CNT_W = $clog2(MAX_SHARDS + 1);
    localparam int LIM_W    = (SH_CNT_W > CFG_W) ? SH_CNT_W : CFG_W;

    // Configuration and item store.
    logic [CFG_W-1:0]    active_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ID_W-1:0]     ids_mem   [MAX_ITEMS];
    logic [LOAD_W-1:0]   loads_mem [MAX_ITEMS];
    logic [ID_W-1:0]     rd_id_reg;
    logic [LOAD_W-1:0]   rd_load_reg;
    logic                item_we;

    // Max scan over the stored items.
    logic [CNT_W-1:0]    ic_reg, ic_next;
    logic                ip_valid_reg, ip_valid_next;
    logic [IT_IDX_W-1:0] ip_idx_reg;
    logic                item_rd;
    logic                best_cand;
    logic                best_valid_reg, best_valid_next;
    logic [IT_IDX_W-1:0] best_idx_reg;
    logic [LOAD_W-1:0]   best_load_reg;
    logic [ID_W-1:0]     best_id_reg;
    logic [MAX_ITEMS-1:0] taken_reg, taken_next;
    logic [CNT_W-1:0]    asg_reg, asg_next;

    // Shard totals and min scan.
    logic [TOTAL_W-1:0]  totals_mem [MAX_SHARDS];
    logic [TOTAL_W-1:0]  tot_rd_reg;
    logic                tot_we;
    logic [SH_IDX_W-1:0] tot_waddr;
    logic [TOTAL_W-1:0]  tot_wdata;
    logic [SH_CNT_W-1:0] sc_reg, sc_next;
    logic                sp_valid_reg, sp_valid_next;
    logic [SH_IDX_W-1:0] sp_idx_reg;
    logic                shard_rd;
    logic                min_cand;
    logic                min_valid_reg, min_valid_next;
    logic [SH_IDX_W-1:0] min_shard_reg;
    logic [TOTAL_W-1:0]  min_total_reg;
    logic [LIM_W-1:0]    act_ext;
    logic [SH_CNT_W-1:0] shard_limit;

    // Output word.
    logic                out_valid_reg, out_valid_next;
    logic [ID_W-1:0]     out_id_reg;
    logic [SHARD_W-1:0]  out_shard_reg;
    logic                out_last_reg;

    // Effective shard count: zero acts as one, large values clamp to MAX_SHARDS.
    assign act_ext = LIM_W'(active_reg);
    always_comb
    begin
        if (act_ext == '0)
        begin
            shard_limit = SH_CNT_W'(1);
        end
        else if (act_ext > LIM_W'(MAX_SHARDS))
        begin
            shard_limit = SH_CNT_W'(MAX_SHARDS);
        end
        else
        begin
            shard_limit = SH_CNT_W'(act_ext);
        end
    end

    // Item store: write at the fill count, registered read for the scan.
    assign item_we = in_accept && (count_reg < CNT_W'(MAX_ITEMS));
    always_ff @(posedge clk)
    begin
        if (item_we)
        begin
            ids_mem[count_reg[IT_IDX_W-1:0]]   <= in_id;
            loads_mem[count_reg[IT_IDX_W-1:0]] <= in_load;
        end
        rd_id_reg   <= ids_mem[ic_reg[IT_IDX_W-1:0]];
        rd_load_reg <= loads_mem[ic_reg[IT_IDX_W-1:0]];
    end

    // Shard totals: cleared per batch, updated on each assignment.
    assign tot_we    = cmd.clr_run || cmd.assign_item;
    assign tot_waddr = cmd.clr_run ? sc_reg[SH_IDX_W-1:0] : min_shard_reg;
    assign tot_wdata = cmd.clr_run ? '0 : (min_total_reg + TOTAL_W'(best_load_reg));
    always_ff @(posedge clk)
    begin
        if (tot_we)
        begin
            totals_mem[tot_waddr] <= tot_wdata;
        end
        tot_rd_reg <= totals_mem[sc_reg[SH_IDX_W-1:0]];
    end

    // Max scan: the first untaken item of the largest load wins, keeping ties stable.
    assign item_rd   = cmd.find_run && (ic_reg < count_reg);
    assign best_cand = ip_valid_reg && !taken_reg[ip_idx_reg]
                       && (!best_valid_reg || (rd_load_reg > best_load_reg));

    // Min scan: the lowest-index shard with the least total wins.
    assign shard_rd = cmd.min_run && (sc_reg < shard_limit);
    assign min_cand = sp_valid_reg && (!min_valid_reg || (tot_rd_reg < min_total_reg));

    // Next values of the control registers.
    always_comb
    begin
        count_next      = count_reg;
        ic_next         = ic_reg;
        ip_valid_next   = item_rd;
        best_valid_next = best_valid_reg;
        taken_next      = taken_reg;
        asg_next        = asg_reg;
        sc_next         = sc_reg;
        sp_valid_next   = shard_rd;
        min_valid_next  = min_valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (item_we)
        begin
            count_next = count_reg + CNT_W'(1);
        end

        if (cmd.find_init)
        begin
            ic_next         = '0;
            best_valid_next = 1'b0;
        end
        else if (item_rd)
        begin
            ic_next = ic_reg + CNT_W'(1);
        end
        if (best_cand)
        begin
            best_valid_next = 1'b1;
        end

        if (cmd.clr_init || cmd.min_init)
        begin
            sc_next        = '0;
            min_valid_next = 1'b0;
        end
        else if (cmd.clr_run || shard_rd)
        begin
            sc_next = sc_reg + SH_CNT_W'(1);
        end
        if (min_cand)
        begin
            min_valid_next = 1'b1;
        end

        if (cmd.assign_item)
        begin
            out_valid_next = 1'b1;
            if (status.last_item)
            begin
                count_next = '0;
                asg_next   = '0;
                taken_next = '0;
            end
            else
            begin
                asg_next                 = asg_reg + CNT_W'(1);
                taken_next[best_idx_reg] = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= CFG_W'(1);
            count_reg      <= '0;
            ic_reg         <= '0;
            ip_valid_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
            taken_reg      <= '0;
            asg_reg        <= '0;
            sc_reg         <= '0;
            sp_valid_reg   <= 1'b0;
            min_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                active_reg <= cfg_data;
            end
            count_reg      <= count_next;
            ic_reg         <= ic_next;
            ip_valid_reg   <= ip_valid_next;
            best_valid_reg <= best_valid_next;
            taken_reg      <= taken_next;
            asg_reg        <= asg_next;
            sc_reg         <= sc_next;
            sp_valid_reg   <= sp_valid_next;
            min_valid_reg  <= min_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ip_idx_reg <= ic_reg[IT_IDX_W-1:0];
        sp_idx_reg <= sc_reg[SH_IDX_W-1:0];
        if (best_cand)
        begin
            best_idx_reg  <= ip_idx_reg;
            best_load_reg <= rd_load_reg;
            best_id_reg   <= rd_id_reg;
        end
        if (min_cand)
        begin
            min_shard_reg <= sp_idx_reg;
            min_total_reg <= tot_rd_reg;
        end
        if (cmd.assign_item)
        begin
            out_id_reg    <= best_id_reg;
            out_shard_reg <= SHARD_W'(min_shard_reg);
            out_last_reg  <= status.last_item;
        end
    end

    // Status back to the controller.
    assign status.clr_done  = (sc_reg == SH_CNT_W'(MAX_SHARDS - 1));
    assign status.find_done = (ic_reg == count_reg) && !ip_valid_reg;
    assign status.min_done  = (sc_reg == shard_limit) && !sp_valid_reg;
    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.last_item = (asg_reg == (count_reg - CNT_W'(1)));

    assign out_valid = out_valid_reg;
    assign out_id    = out_id_reg;
    assign out_shard = out_shard_reg;
    assign out_last  = out_last_reg;

    // The fill count never passes the store depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("item count beyond store depth");

    // An assignment never overwrites a word still waiting at the output.
    a_assign_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.assign_item |-> (!out_valid_reg || out_ready))
        else $error("assignment while output word blocked");

    // The assigned item was found by the scan and was not assigned before.
    a_best_untaken: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.assign_item |-> (best_valid_reg && !taken_reg[best_idx_reg]))
        else $error("assigned item invalid or already taken");

    // The chosen shard lies within the active shard count.
    a_shard_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.assign_item |-> (min_valid_reg && (SH_CNT_W'(min_shard_reg) < shard_limit)))
        else $error("chosen shard outside active range");

    // The last assignment of a batch empties the store and the taken marks.
    a_batch_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.assign_item && status.last_item) |=> ((count_reg == '0) && (taken_reg == '0)))
        else $error("batch state not cleared at batch end");

endmodule

// ===== hdl/lpt_shard_assigner.sv =====
// Longest-processing-time-first shard assigner, top level.
// Channels: item_in (sink) takes words of item_id, item_load and batch_last;
// result_out (source) gives one word of out_id, shard_index and out_last per item.
// cfg_we/cfg_data write active_shards (0 acts as 1, above MAX_SHARDS clamps).
// Items load one per cycle into a MAX_ITEMS-entry store; items beyond it are
// dropped. After the word with batch_last, item_in.ready falls and the block
// clears MAX_SHARDS shard totals, one per cycle. Then for each of the n stored
// items it scans the store for the largest untaken load (one memory read per
// cycle), scans the active shards for the least total and writes one result
// word. The result register holds a word until result_out.ready; a stalled
// receiver holds the assignment step. After the last result is loaded,
// item_in.ready rises again even while that word waits. Reset empties the
// store, the output register and the controller, and sets active_shards to 1.
// Depends on lpt_pkg, lpt_channels, lpt_ctrl and lpt_datapath.
module lpt_shard_assigner import lpt_pkg::*;
#(
    parameter int MAX_ITEMS  = 64,
    parameter int MAX_SHARDS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    lpt_item_if.sink         item_in,
    lpt_result_if.source     result_out
);

    lpt_cmd_t    cmd;
    lpt_status_t status;
    logic        in_ready;
    logic        in_accept;

    // Input handshake.
    assign item_in.ready = in_ready;
    assign in_accept     = item_in.valid && in_ready;

    // Controller.
    lpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item_in.valid),
        .in_last  (item_in.batch_last),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // Datapath.
    lpt_datapath #(
        .MAX_ITEMS  (MAX_ITEMS),
        .MAX_SHARDS (MAX_SHARDS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .in_id     (item_in.item_id),
        .in_load   (item_in.item_load),
        .cmd       (cmd),
        .status    (status),
        .out_ready (result_out.ready),
        .out_valid (result_out.valid),
        .out_id    (result_out.out_id),
        .out_shard (result_out.shard_index),
        .out_last  (result_out.out_last)
    );

endmodule

// ===== sim/tb_lpt_shard_assigner.sv =====
`timescale 1ns / 1ps
// Testbench for lpt_shard_assigner: sends batches of words, predicts each assignment
// with its own LPT scheduler and checks every result word against it.
// Depends on lpt_pkg, lpt_channels and the lpt_shard_assigner RTL.
module tb;
    import lpt_pkg::*;

    localparam int MAX_ITEMS      = 64;
    localparam int MAX_SHARDS     = 16;
    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 50;
    localparam int LONG_STALL     = 400;
    localparam int TIMEOUT_CYCLES = 500000;
    localparam int MAX_REPORTS    = 100;

    // Idle rates in percent for traffic profiles A and B.
    localparam int SEND_IDLE_A = 18;
    localparam int RECV_IDLE_A = 67;
    localparam int SEND_IDLE_B = 67;
    localparam int RECV_IDLE_B = 18;

    // Load distributions for a batch.
    typedef enum int {
        LOAD_WIDE,
        LOAD_NARROW,
        LOAD_EXTREME
    } load_mix_t;

    // One expected result word.
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SHARD_W-1:0] shard;
        logic               last;
    } assignment_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CFG_W-1:0]   cfg_data;

    lpt_item_if   item_bus ();
    lpt_result_if result_bus ();

    // Shadow state of the scheduler.
    logic [ID_W-1:0]    batch_ids [MAX_ITEMS];
    logic [LOAD_W-1:0]  batch_loads [MAX_ITEMS];
    int                 batch_fill;
    logic [CFG_W-1:0]   shard_setting;
    assignment_t        pending_assignments [$];

    int  mismatch_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  long_stall_req;

    lpt_shard_assigner #(
        .MAX_ITEMS  (MAX_ITEMS),
        .MAX_SHARDS (MAX_SHARDS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .item_in    (item_bus),
        .result_out (result_bus)
    );

    // Clock generation.
    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Store one accepted word; on the batch's last word, schedule the whole batch.
    // Loads are taken largest first, earliest arrival on equal loads, and each goes
    // to the least loaded active shard, lowest index on equal totals.
    function automatic void predict_assignments(input logic [ID_W-1:0] id,
                                                input logic [LOAD_W-1:0] load,
                                                input logic last);
        logic [TOTAL_W-1:0] totals [MAX_SHARDS];
        bit                 taken [MAX_ITEMS];
        int                 n;
        int                 shards;
        int                 pick;
        int                 best;
        assignment_t        a;

        if (batch_fill < MAX_ITEMS)
        begin
            batch_ids[batch_fill]   = id;
            batch_loads[batch_fill] = load;
            batch_fill++;
        end
        if (!last)
            return;

        n = batch_fill;
        if (shard_setting == 0)
            shards = 1;
        else if (shard_setting > MAX_SHARDS)
            shards = MAX_SHARDS;
        else
            shards = int'(shard_setting);

        for (int s = 0; s < MAX_SHARDS; s++)
            totals[s] = '0;
        for (int i = 0; i < MAX_ITEMS; i++)
            taken[i] = 1'b0;

        for (int k = 0; k < n; k++)
        begin
            pick = -1;
            for (int i = 0; i < n; i++)
            begin
                if (!taken[i] && (pick < 0 || batch_loads[i] > batch_loads[pick]))
                    pick = i;
            end
            taken[pick] = 1'b1;

            best = 0;
            for (int s = 1; s < shards; s++)
            begin
                if (totals[s] < totals[best])
                    best = s;
            end
            totals[best] = totals[best] + TOTAL_W'(batch_loads[pick]);

            a.id    = batch_ids[pick];
            a.shard = best[SHARD_W-1:0];
            a.last  = (k == n - 1);
            pending_assignments.insert(pending_assignments.size(), a);
        end
        batch_fill = 0;
    endfunction

    // Offer one word, with random idle cycles first, and wait for its acceptance.
    task automatic send_word(input logic [ID_W-1:0] id, input logic [LOAD_W-1:0] load,
                             input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid      <= 1'b1;
        item_bus.item_id    <= id;
        item_bus.item_load  <= load;
        item_bus.batch_last <= last;
        @(posedge clk);
        while (item_bus.ready !== 1'b1)
            @(posedge clk);
        predict_assignments(id, load, last);
    endtask

    function automatic logic [LOAD_W-1:0] pick_load(input load_mix_t mix);
        logic [LOAD_W-1:0] load;

        case (mix)
            LOAD_NARROW: load = $urandom_range(0, 7);
            LOAD_EXTREME:
                case ($urandom_range(3))
                    0:       load = '0;
                    1:       load = 32'd1;
                    2:       load = '1;
                    default: load = 32'hFFFF_FFFE;
                endcase
            default:     load = $urandom;
        endcase
        return load;
    endfunction

    // A batch of random ids and loads; only its final word is marked last.
    task automatic send_batch(input int count, input load_mix_t mix);
        for (int i = 0; i < count; i++)
            send_word(ID_W'($urandom), pick_load(mix), i == count - 1);
    endtask

    // Wait until every predicted word has come out and the block has gone quiet.
    task automatic settle();
        item_bus.valid <= 1'b0;
        while (pending_assignments.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_shard_setting(input logic [CFG_W-1:0] value);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        shard_setting = value;
    endtask

    // Reset value of the shard count: everything lands on shard 0.
    task automatic test_reset_defaults();
        send_word(16'h0000, 32'h0000_0000, 1'b0);
        send_word(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        send_word(16'h1234, 32'h0000_0005, 1'b1);
    endtask

    // Equal loads keep arrival order and fill shards from the lowest index;
    // a one-word batch follows.
    task automatic test_ties_and_single();
        write_shard_setting(5'd4);
        for (int i = 0; i < 5; i++)
            send_word(ID_W'(16'h0010 + i), 32'd7, i == 4);
        send_word(16'hA5A5, 32'd9, 1'b1);
    endtask

    // A shard count of zero acts as one, and a count above the maximum is clamped.
    task automatic test_shard_count_limits();
        write_shard_setting(5'd0);
        send_word(16'h0100, 32'd3, 1'b0);
        send_word(16'h0101, 32'd1, 1'b0);
        send_word(16'h0102, 32'd2, 1'b1);
        write_shard_setting(5'd31);
        send_batch(4, LOAD_WIDE);
    endtask

    // Shard totals beyond 32 bits: the third maximum load lifts shard 0 past
    // 2^32, so the final unit load must go to shard 1.
    task automatic test_total_width();
        write_shard_setting(5'd2);
        send_word(16'h0200, 32'd1, 1'b0);
        send_word(16'h0201, 32'hFFFF_FFFF, 1'b0);
        send_word(16'h0202, 32'hFFFF_FFFF, 1'b0);
        send_word(16'h0203, 32'hFFFF_FFFF, 1'b1);
    endtask

    // A full store with many ties, then a batch whose extra words, the last
    // one among them, are dropped while the stored batch is still scheduled.
    task automatic test_store_overflow();
        write_shard_setting(5'd16);
        send_batch(MAX_ITEMS, LOAD_NARROW);
        send_batch(MAX_ITEMS + 2, LOAD_WIDE);
    endtask

    // Random batches with occasional shard count changes between them.
    task automatic test_random_batches(input int goal, input int s_idle, input int r_idle);
        int        sent;
        int        size;
        int        roll;
        load_mix_t mix;

        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        sent = 0;
        while (sent < goal)
        begin
            roll = $urandom_range(99);
            if (roll < 3)
                size = MAX_ITEMS;
            else if (roll < 10)
                size = $urandom_range(13, 30);
            else
                size = $urandom_range(1, 12);
            mix = load_mix_t'($urandom_range(2));
            if ($urandom_range(3) == 0)
            begin
                if ($urandom_range(9) == 0)
                    write_shard_setting(CFG_W'($urandom_range(0, 31)));
                else
                    write_shard_setting(CFG_W'($urandom_range(1, 16)));
            end
            send_batch(size, mix);
            sent += size;
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering,
    // so the result register fills and the input stalls.
    task automatic test_backpressure();
        write_shard_setting(5'd3);
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        long_stall_req = 1'b1;
        send_batch(8, LOAD_WIDE);
        send_batch(6, LOAD_NARROW);
    endtask

    // Receiver: checks each accepted result word, then chooses the next ready.
    initial
    begin
        assignment_t want;
        int          stall_left;

        stall_left = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            begin
                if (pending_assignments.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word id=%h shard=%0d last=%0b",
                        result_bus.out_id, result_bus.shard_index, result_bus.out_last));
                end
                else
                begin
                    want = pending_assignments.pop_front();
                    if (result_bus.out_id !== want.id)
                        report_mismatch($sformatf("out_id %h, expected %h",
                            result_bus.out_id, want.id));
                    if (result_bus.shard_index !== want.shard)
                        report_mismatch($sformatf("shard_index %0d, expected %0d (id %h)",
                            result_bus.shard_index, want.shard, want.id));
                    if (result_bus.out_last !== want.last)
                        report_mismatch($sformatf("out_last %0b, expected %0b (id %h)",
                            result_bus.out_last, want.last, want.id));
                end
            end

            if (long_stall_req)
            begin
                stall_left     = LONG_STALL;
                long_stall_req = 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Test sequence.
    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_data            = '0;
        item_bus.valid      = 1'b0;
        item_bus.item_id    = '0;
        item_bus.item_load  = '0;
        item_bus.batch_last = 1'b0;
        batch_fill          = 0;
        shard_setting       = 5'd1;
        mismatch_count      = 0;
        long_stall_req      = 1'b0;
        send_idle_pct       = SEND_IDLE_A;
        recv_idle_pct       = RECV_IDLE_A;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_ties_and_single();
        test_shard_count_limits();
        test_total_width();
        test_store_overflow();
        test_random_batches(100, SEND_IDLE_A, RECV_IDLE_A);
        test_random_batches(100, SEND_IDLE_B, RECV_IDLE_B);
        test_random_batches(100, 0, 0);
        test_backpressure();
        settle();

        if (mismatch_count == 0 && pending_assignments.size() == 0)
            $display("** lpt_shard_assigner: PASSED **");
        else
            $display("** lpt_shard_assigner: FAILED **");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("** lpt_shard_assigner: FAILED **");
        $finish;
    end

endmodule
